// ----- src/dlms_pkg.sv -----
package dlms_pkg;

    // fixed field widths
    localparam int STATE_FW  = 6;
    localparam int SYMBOL_FW = 8;
    localparam int LEN_W     = 16;

    // table geometry
    localparam int STATES   = 64;
    localparam int ALPHA    = 128;
    localparam int STATE_AW = $clog2(STATES);
    localparam int TT_DEPTH = STATES * ALPHA;
    localparam int TT_AW    = $clog2(TT_DEPTH);

    // result buffer
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    // stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        FUNC_TRANS  = 2'd0,
        FUNC_FINAL  = 2'd1,
        FUNC_SYMBOL = 2'd2
    } func_t;

    typedef struct packed {
        logic                valid;
        logic [STATE_FW-1:0] next_state;
    } tt_entry_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [TT_AW-1:0] addr;
        tt_entry_t        wdata;
    } tt_req_t;

    typedef struct packed {
        logic             matched;
        logic [LEN_W-1:0] match_length;
    } result_t;

endpackage

// ----- src/dlms_trans_mem.sv -----
module dlms_trans_mem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dlms_pkg::tt_req_t     req,
    output dlms_pkg::tt_entry_t   rd_data,
    output logic                  busy
);

    dlms_pkg::tt_entry_t                mem_reg [dlms_pkg::TT_DEPTH];
    dlms_pkg::tt_entry_t                rd_data_reg;
    logic [dlms_pkg::TT_AW-1:0]         clr_addr_reg;
    logic                               busy_reg;

    // clearing sweep after reset, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == dlms_pkg::TT_AW'(dlms_pkg::TT_DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem_reg[clr_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem_reg[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem_reg[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ----- src/dlms_final_mem.sv -----
module dlms_final_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [dlms_pkg::STATE_AW-1:0] wr_addr,
    input  logic                          wr_data,
    input  logic                          rd_en,
    input  logic [dlms_pkg::STATE_AW-1:0] rd_addr,
    output logic                          rd_data
);

    logic [dlms_pkg::STATES-1:0] marks_reg;
    logic                        rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else if (wr_en)
        begin
            marks_reg[wr_addr] <= wr_data;
        end
    end

    // read sees the mark as it stood before a write on the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= marks_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/dlms_out_fifo.sv -----
module dlms_out_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  dlms_pkg::result_t            push_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output dlms_pkg::result_t            out_data,
    output logic [dlms_pkg::OUT_CW-1:0]  count
);

    dlms_pkg::result_t               mem_reg [dlms_pkg::OUT_DEPTH];
    logic [dlms_pkg::OUT_AW-1:0]     wr_ptr_reg;
    logic [dlms_pkg::OUT_AW-1:0]     rd_ptr_reg;
    logic [dlms_pkg::OUT_CW-1:0]     count_reg;
    logic                            pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/dfa_longest_match_scanner.sv -----
// table-driven dfa scanner returning the longest accepted prefix of a string. every input
// word (table write, final mark write or string symbol) is taken at one word per cycle, back
// to back while the result buffer has room, since each word makes at most one access to the
// single-port transition table and the registered read data of one symbol drives the read
// address of the next. a symbol flagged last has its result word offered once it has passed
// the table read, the final mark read and the result buffer; a four-word result buffer
// keeps words flowing while results wait. after reset the transition table is cleared by a
// sweep over its STATES*ALPHA entries (8192), during which no input word is taken;
// start_state writes are taken at any time.
module dfa_longest_match_scanner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // state_index [5:0], symbol [13:6], target_state [19:14], flag_value [20], zero above
    input  logic [dlms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func [1:0]
    input  logic [1:0]                         s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // match_length [15:0], matched [16], zero above
    output logic [dlms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dlms_pkg::STATE_FW-1:0]      cfg_data
);

    // input word fields
    logic [dlms_pkg::STATE_FW-1:0]  in_state_index;
    logic [dlms_pkg::SYMBOL_FW-1:0] in_symbol;
    logic [dlms_pkg::STATE_FW-1:0]  in_target_state;
    logic                           in_flag_value;
    dlms_pkg::func_t                in_func;
    logic                           in_acc;
    logic                           sym_acc;

    logic [dlms_pkg::STATE_FW-1:0]  start_state_reg;

    // walk state
    logic [dlms_pkg::STATE_FW-1:0]  walk_cur_reg;
    logic [dlms_pkg::STATE_FW-1:0]  walk_cur_next;
    logic [dlms_pkg::LEN_W-1:0]     walk_taken_reg;
    logic [dlms_pkg::LEN_W-1:0]     walk_taken_next;
    logic                           walk_stop_reg;
    logic                           walk_stop_next;

    // stage 0 decode
    logic [dlms_pkg::STATE_FW-1:0]  sym_cur;
    logic                           sym_bad;
    logic                           sym_look;
    logic [dlms_pkg::STATE_FW-1:0]  addr_state;
    dlms_pkg::tt_req_t              tt_req;
    dlms_pkg::tt_entry_t            tt_entry;
    logic                           tt_busy;

    // stage 1
    logic                           s1_valid_reg;
    logic                           s1_last_reg;
    logic                           s1_look_reg;
    logic [dlms_pkg::STATE_FW-1:0]  s1_cur_reg;
    logic [dlms_pkg::LEN_W-1:0]     s1_taken_reg;
    logic                           s1_hit;
    logic [dlms_pkg::LEN_W-1:0]     s1_taken_inc;

    // stage 2
    logic                           s2_valid_reg;
    logic                           s2_last_reg;
    logic                           s2_adv_reg;
    logic [dlms_pkg::LEN_W-1:0]     s2_len_reg;
    logic                           fm_rd_data;
    logic                           s2_accept;
    logic                           acc_reg;
    logic                           acc_next;
    logic [dlms_pkg::LEN_W-1:0]     best_reg;
    logic [dlms_pkg::LEN_W-1:0]     best_next;
    logic                           acc_new;
    logic [dlms_pkg::LEN_W-1:0]     best_new;

    // result path
    logic                           out_push;
    dlms_pkg::result_t              out_push_data;
    dlms_pkg::result_t              out_data;
    logic [dlms_pkg::OUT_CW-1:0]    fifo_count;
    logic                           s1_pend;
    logic                           s2_pend;

    assign in_state_index  = s_axis_tdata[5:0];
    assign in_symbol       = s_axis_tdata[13:6];
    assign in_target_state = s_axis_tdata[19:14];
    assign in_flag_value   = s_axis_tdata[20];
    assign in_func         = dlms_pkg::func_t'(s_axis_tuser);

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign sym_acc = in_acc && (in_func == dlms_pkg::FUNC_SYMBOL);

    // room for every result still in flight
    assign s1_pend = s1_valid_reg && s1_last_reg;
    assign s2_pend = s2_valid_reg && s2_last_reg;
    assign s_axis_tready = !tt_busy &&
        ((int'(fifo_count) + int'(s1_pend) + int'(s2_pend)) < dlms_pkg::OUT_DEPTH);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_state_reg <= cfg_data;
        end
    end

    // stage 0: walk state forwarded from stage 1, table address
    assign sym_cur  = (walk_taken_next == '0) ? start_state_reg : walk_cur_next;
    assign sym_bad  = (in_symbol == '0) || (int'(in_symbol) >= dlms_pkg::ALPHA) ||
                      (int'(sym_cur) >= dlms_pkg::STATES);
    assign sym_look = !walk_stop_next && !sym_bad;

    assign addr_state = (in_func == dlms_pkg::FUNC_TRANS) ? in_state_index : sym_cur;

    always_comb
    begin
        tt_req.wr_en = in_acc && (in_func == dlms_pkg::FUNC_TRANS) &&
                       (int'(in_state_index) < dlms_pkg::STATES) &&
                       (int'(in_symbol) < dlms_pkg::ALPHA) &&
                       (int'(in_target_state) < dlms_pkg::STATES);
        tt_req.rd_en = sym_acc && sym_look;
        tt_req.addr  = dlms_pkg::TT_AW'(int'(addr_state) * dlms_pkg::ALPHA + int'(in_symbol));
        tt_req.wdata.valid      = in_flag_value;
        tt_req.wdata.next_state = in_target_state;
    end

    dlms_trans_mem u_trans_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tt_req),
        .rd_data (tt_entry),
        .busy    (tt_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= sym_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg  <= s_axis_tlast;
        s1_look_reg  <= sym_look;
        s1_cur_reg   <= sym_cur;
        s1_taken_reg <= walk_taken_next;
    end

    // stage 1: transition resolves
    assign s1_hit       = s1_valid_reg && s1_look_reg && tt_entry.valid;
    assign s1_taken_inc = (s1_taken_reg == '1) ? s1_taken_reg : s1_taken_reg + 1'b1;

    always_comb
    begin
        walk_cur_next   = walk_cur_reg;
        walk_taken_next = walk_taken_reg;
        walk_stop_next  = walk_stop_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                walk_cur_next   = s1_cur_reg;
                walk_taken_next = '0;
                walk_stop_next  = 1'b0;
            end
            else if (s1_hit)
            begin
                walk_cur_next   = tt_entry.next_state;
                walk_taken_next = s1_taken_inc;
                walk_stop_next  = 1'b0;
            end
            else
            begin
                walk_cur_next   = s1_cur_reg;
                walk_taken_next = s1_taken_reg;
                walk_stop_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cur_reg   <= '0;
            walk_taken_reg <= '0;
            walk_stop_reg  <= 1'b0;
        end
        else
        begin
            walk_cur_reg   <= walk_cur_next;
            walk_taken_reg <= walk_taken_next;
            walk_stop_reg  <= walk_stop_next;
        end
    end

    dlms_final_mem u_final_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_acc && (in_func == dlms_pkg::FUNC_FINAL) &&
                  (int'(in_state_index) < dlms_pkg::STATES)),
        .wr_addr (dlms_pkg::STATE_AW'(in_state_index)),
        .wr_data (in_flag_value),
        .rd_en   (s1_hit),
        .rd_addr (dlms_pkg::STATE_AW'(tt_entry.next_state)),
        .rd_data (fm_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg <= s1_last_reg;
        s2_adv_reg  <= s1_hit;
        s2_len_reg  <= s1_taken_inc;
    end

    // stage 2: final mark check and result
    assign s2_accept = s2_valid_reg && s2_adv_reg && fm_rd_data;
    assign acc_new   = acc_reg || s2_accept;
    assign best_new  = s2_accept ? s2_len_reg : best_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        best_next = best_reg;
        if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                acc_next  = 1'b0;
                best_next = '0;
            end
            else
            begin
                acc_next  = acc_new;
                best_next = best_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            best_reg <= best_next;
        end
    end

    assign out_push                   = s2_valid_reg && s2_last_reg;
    assign out_push_data.matched      = acc_new;
    assign out_push_data.match_length = acc_new ? best_new : '0;

    dlms_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_push_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {{(dlms_pkg::OUT_TDATA_W - dlms_pkg::LEN_W - 1){1'b0}},
                           out_data.matched, out_data.match_length};

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (int'(fifo_count) < dlms_pkg::OUT_DEPTH))
        else $error("result pushed into a full buffer");

    a_tt_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(tt_req.wr_en && tt_req.rd_en))
        else $error("transition table read and written in one cycle");

    a_s1_origin: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(sym_acc))
        else $error("stage 1 holds a symbol that was never taken");

    a_walk_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |=> (!acc_reg && (best_reg == '0)))
        else $error("match state not cleared after last symbol");

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [1:0]                    func;
        logic [dlms_pkg::STATE_FW-1:0] state_index;
        logic [7:0]                    symbol;
        logic [dlms_pkg::STATE_FW-1:0] target_state;
        logic                          flag_value;
        logic                          is_last;
    } scan_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [dlms_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [dlms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dlms_pkg::STATE_FW-1:0]    cfg_data = '0;

    // shadow of the scanner
    bit                            tt_valid [dlms_pkg::STATES][dlms_pkg::ALPHA];
    logic [dlms_pkg::STATE_FW-1:0] tt_next [dlms_pkg::STATES][dlms_pkg::ALPHA];
    bit                            accept_mark [dlms_pkg::STATES];
    logic [dlms_pkg::STATE_FW-1:0] start_reg = '0;
    logic [dlms_pkg::STATE_FW-1:0] walk_state = '0;
    int unsigned                   walk_len = 0;
    int unsigned                   best_len = 0;
    bit                            walk_hit = 1'b0;
    bit                            walk_dead = 1'b0;

    dlms_pkg::result_t pending_lengths [$];
    int                err_count = 0;
    bit                idle_en = 1'b1;
    int                rx_hold = 0;
    int                rx_gap = 0;

    dfa_longest_match_scanner u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    function automatic scan_word_t mk_word(input logic [1:0] func, input int si, input int sym,
                                           input int tgt, input bit flag, input bit is_last);
        scan_word_t w;
        w.func         = func;
        w.state_index  = dlms_pkg::STATE_FW'(si);
        w.symbol       = 8'(sym);
        w.target_state = dlms_pkg::STATE_FW'(tgt);
        w.flag_value   = flag;
        w.is_last      = is_last;
        return w;
    endfunction

    function automatic scan_word_t sym_word(input int sym, input bit is_last);
        return mk_word(dlms_pkg::FUNC_SYMBOL, $urandom_range(0, 63), sym, $urandom_range(0, 63),
                       1'($urandom_range(0, 1)), is_last);
    endfunction

    function automatic void clear_walk();
        walk_state = start_reg;
        walk_len   = 0;
        best_len   = 0;
        walk_hit   = 1'b0;
        walk_dead  = 1'b0;
    endfunction

    function automatic void walk_symbol(input logic [7:0] sym);
        if (walk_dead)
            return;
        if (walk_len == 0)
            walk_state = start_reg;
        if (sym == 0 || sym >= dlms_pkg::ALPHA || !tt_valid[walk_state][sym[6:0]])
        begin
            walk_dead = 1'b1;
            return;
        end
        walk_state = tt_next[walk_state][sym[6:0]];
        if (walk_len < 65535)
            walk_len++;
        // an empty prefix never counts, only states reached by a symbol
        if (accept_mark[walk_state])
        begin
            best_len = walk_len;
            walk_hit = 1'b1;
        end
    endfunction

    function automatic void apply_word(input scan_word_t w);
        dlms_pkg::result_t r;
        case (w.func)
            dlms_pkg::FUNC_TRANS:
                if (w.symbol < dlms_pkg::ALPHA)
                begin
                    tt_valid[w.state_index][w.symbol[6:0]] = w.flag_value;
                    tt_next[w.state_index][w.symbol[6:0]]  = w.target_state;
                end
            dlms_pkg::FUNC_FINAL:
                accept_mark[w.state_index] = w.flag_value;
            dlms_pkg::FUNC_SYMBOL:
            begin
                walk_symbol(w.symbol);
                if (w.is_last)
                begin
                    r.matched      = walk_hit;
                    r.match_length = walk_hit ? dlms_pkg::LEN_W'(best_len) : '0;
                    pending_lengths.push_back(r);
                    clear_walk();
                end
            end
            default:
                ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at %0t ns: %s, expected %0d, got %0d", $time, what, want, got);
        err_count++;
    endtask

    task automatic send_word(input scan_word_t w);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, w.flag_value, w.target_state, w.symbol, w.state_index};
        s_axis_tuser  <= w.func;
        s_axis_tlast  <= w.is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_word(w);
    endtask

    // hold the input until every result is out, then give the pipeline time to settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_lengths.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_start_state(input int v);
        cfg_valid <= 1'b1;
        cfg_data  <= dlms_pkg::STATE_FW'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        start_reg = dlms_pkg::STATE_FW'(v);
    endtask

    // receiving side: stalls and result checks
    initial
    begin
        dlms_pkg::result_t want;
        int unsigned       got_len;
        bit                got_hit;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_len = 32'(m_axis_tdata[dlms_pkg::LEN_W-1:0]);
                got_hit = m_axis_tdata[dlms_pkg::LEN_W];
                if (pending_lengths.size() == 0)
                    report_mismatch("result word with nothing pending", 0, got_len);
                else
                begin
                    want = pending_lengths.pop_front();
                    if (m_axis_tdata[dlms_pkg::LEN_W-1:0] !== want.match_length)
                        report_mismatch("match_length", 32'(want.match_length), got_len);
                    if (m_axis_tdata[dlms_pkg::LEN_W] !== want.matched)
                        report_mismatch("matched", 32'(want.matched), 32'(got_hit));
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                rx_gap = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_word(mk_word(dlms_pkg::FUNC_TRANS, 0, 1, 1, 1'b1, 1'b0));
        send_word(mk_word(dlms_pkg::FUNC_TRANS, 1, 2, 2, 1'b1, 1'b0));
        send_word(mk_word(dlms_pkg::FUNC_TRANS, 2, 127, 63, 1'b1, 1'b0));
        send_word(mk_word(dlms_pkg::FUNC_FINAL, 2, 0, 0, 1'b1, 1'b0));
        send_word(mk_word(dlms_pkg::FUNC_FINAL, 63, 0, 0, 1'b1, 1'b0));
        // start state accepting, tlast on a mark write
        send_word(mk_word(dlms_pkg::FUNC_FINAL, 0, 0, 0, 1'b1, 1'b1));
        // symbol beyond the alphabet: write dropped
        send_word(mk_word(dlms_pkg::FUNC_TRANS, 0, 200, 5, 1'b1, 1'b1));
        send_word(mk_word(FUNC_SPARE, 63, 255, 63, 1'b1, 1'b1));
        send_word(sym_word(1, 1'b0));
        send_word(sym_word(2, 1'b0));
        send_word(sym_word(127, 1'b1));
        // missing transition straight away, accepting start must not count
        send_word(sym_word(5, 1'b1));
        // zero symbol stops the walk, later symbols ignored until tlast
        send_word(sym_word(1, 1'b0));
        send_word(sym_word(2, 1'b0));
        send_word(sym_word(0, 1'b0));
        send_word(sym_word(127, 1'b1));
        // out of range symbol on the closing word
        send_word(sym_word(1, 1'b0));
        send_word(sym_word(2, 1'b0));
        send_word(sym_word(255, 1'b1));
        send_word(sym_word(200, 1'b1));
        // invalidate an entry and walk it again
        send_word(mk_word(dlms_pkg::FUNC_TRANS, 2, 127, 63, 1'b0, 1'b0));
        send_word(sym_word(1, 1'b0));
        send_word(sym_word(2, 1'b0));
        send_word(sym_word(127, 1'b1));
    endtask

    task automatic test_random();
        logic [dlms_pkg::STATE_FW-1:0] pool_st [8];
        logic [7:0]                    pool_sym [6];
        int                            phase;
        int                            n;
        int                            k;
        int                            len;
        int                            roll;
        int                            sym;
        for (phase = 0; phase < 6; phase++)
        begin
            idle_en = (phase != 2);
            wait_drained();
            case (phase)
                0:       write_start_state(63);
                1:       write_start_state(0);
                default: write_start_state($urandom_range(0, 63));
            endcase
            pool_st[0] = start_reg;
            for (k = 1; k < 8; k++)
                pool_st[k] = dlms_pkg::STATE_FW'($urandom_range(0, 63));
            for (k = 0; k < 6; k++)
                pool_sym[k] = 8'($urandom_range(1, 127));
            // small automaton over a few states and symbols so walks go deep
            for (k = 0; k < 20; k++)
                send_word(mk_word(dlms_pkg::FUNC_TRANS, pool_st[$urandom_range(0, 7)],
                                  pool_sym[$urandom_range(0, 5)], pool_st[$urandom_range(0, 7)],
                                  1'b1, 1'($urandom_range(0, 1))));
            for (k = 0; k < 3; k++)
                send_word(mk_word(dlms_pkg::FUNC_FINAL, pool_st[$urandom_range(0, 7)], 0, 0,
                                  1'b1, 1'b0));
            n = 23;
            while (n < 150)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    send_word(mk_word(dlms_pkg::FUNC_TRANS, $urandom_range(0, 63),
                                      $urandom_range(0, 255), $urandom_range(0, 63),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                else if (roll < 12)
                    send_word(mk_word(dlms_pkg::FUNC_FINAL, $urandom_range(0, 63),
                                      $urandom_range(0, 255), $urandom_range(0, 63),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                else if (roll < 14)
                    send_word(mk_word(FUNC_SPARE, $urandom_range(0, 63), $urandom_range(0, 255),
                                      $urandom_range(0, 63), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))));
                else
                begin
                    len = $urandom_range(1, 10);
                    for (k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 9) < 8)
                            sym = pool_sym[$urandom_range(0, 5)];
                        else
                            sym = $urandom_range(0, 255);
                        send_word(sym_word(sym, k == len - 1));
                    end
                    n += len - 1;
                end
                n++;
            end
        end
        idle_en = 1'b1;
    endtask

    // receiver holds off long enough for the result buffer to fill and stall the input
    task automatic test_backpressure();
        int k;
        int len;
        wait_drained();
        rx_hold = 150;
        for (k = 0; k < 40; k++)
        begin
            len = $urandom_range(1, 2);
            if (len == 2)
                send_word(sym_word($urandom_range(1, 127), 1'b0));
            send_word(sym_word($urandom_range(1, 127), 1'b1));
        end
    endtask

    // self loop on an accepting state, one long walk back to back with no idling
    task automatic test_long_walk();
        int k;
        idle_en = 1'b0;
        wait_drained();
        write_start_state(37);
        send_word(mk_word(dlms_pkg::FUNC_TRANS, 37, 3, 37, 1'b1, 1'b0));
        send_word(mk_word(dlms_pkg::FUNC_FINAL, 37, 0, 0, 1'b1, 1'b0));
        for (k = 0; k < 40; k++)
            send_word(sym_word(3, k == 39));
        send_word(sym_word(3, 1'b1));
    endtask

    initial
    begin
        clear_walk();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_long_walk();
        wait_drained();
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/dlms_pkg.sv
src/dlms_trans_mem.sv
src/dlms_final_mem.sv
src/dlms_out_fifo.sv
src/dfa_longest_match_scanner.sv
sim/testbench.sv
